>>> rtl/kalman_pd_head_tracker_core_assert.svh
// Assertion macros for the head tracker core.
`ifndef KALMAN_PD_HEAD_TRACKER_CORE_ASSERT_SVH
`define KALMAN_PD_HEAD_TRACKER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KPD_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define KPD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define KPD_ASSERT_IMP(label, ante, cons)
`define KPD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/kpd_pkg.sv
// Package of types and constants for the head tracker core.
`default_nettype none
package kpd_pkg;
	localparam int unsigned REG_PAN_KP  = 0;
	localparam int unsigned REG_PAN_KD  = 1;
	localparam int unsigned REG_TILT_KP = 2;
	localparam int unsigned REG_TILT_KD = 3;
	localparam int unsigned REG_Y_Q     = 4;
	localparam int unsigned REG_Y_R     = 5;
	localparam int unsigned REG_X_Q     = 6;
	localparam int unsigned REG_X_R     = 7;

	typedef enum logic [3:0] {
		ST_IDLE, ST_AXIS, ST_PRED, ST_DIV, ST_EST, ST_VAR, ST_PD1, ST_PD2, ST_OUT
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic       load;     // capture input item
		logic       sel_axis; // 0 = y/pan, 1 = x/tilt
		logic       pred;     // form predicted variance
		logic       div_go;   // start gain division
		logic       est;      // update estimate
		logic       var_upd;  // update variance
		logic       pd1;      // PD products
		logic       pd2;      // PD sum and clamp
		logic       out_go;   // present result
	} cmd_t;

	typedef struct packed {
		logic       meas_on;
		logic [3:0] passes;   // pass count of the current item
		logic       div_busy;
		logic       out_busy;
	} stat_t;
endpackage
`default_nettype wire

>>> rtl/kpd_if.sv
// Valid/ready channel interfaces for the head tracker core.
`default_nettype none
interface kpd_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] target_x;
	logic [15:0] target_y;
	logic        measure_enable;
	logic [3:0]  filter_passes;
	modport source (output valid, target_x, target_y, measure_enable, filter_passes,
		input ready);
	modport sink (input valid, target_x, target_y, measure_enable, filter_passes,
		output ready);
endinterface

interface kpd_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] pan_position;
	logic [11:0] tilt_position;
	modport source (output valid, pan_position, tilt_position, input ready);
	modport sink (input valid, pan_position, tilt_position, output ready);
endinterface

interface kpd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/kpd_divider.sv
// Restoring divider: 48-bit numerator by 33-bit denominator, one quotient bit a cycle.
`default_nettype none
module kpd_divider
	import kpd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] pt,
	input  wire logic [32:0] den,
	output logic             busy,
	output logic [16:0]      quot
);
	logic [5:0]  cnt_q;
	logic [47:0] num_q;
	logic [32:0] den_q;
	logic [33:0] rem_q;
	logic [16:0] quo_q;
	logic [33:0] trial;

	assign trial = {rem_q[32:0], num_q[47]} - {1'b0, den_q};
	assign busy  = (cnt_q != 6'd0);
	assign quot  = quo_q;

	// one bit of the quotient per cycle; only the low 17 bits can be set
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd48;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {pt, 16'd0};
			den_q <= den;
			rem_q <= 34'd0;
			quo_q <= 17'd0;
		end else if (busy) begin
			num_q <= {num_q[46:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial;
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], num_q[47]};
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/kpd_datapath.sv
// Datapath: per-axis Kalman state, PD state, servo positions and result register.
`default_nettype none
module kpd_datapath
	import kpd_pkg::*;
#(
	parameter int unsigned PAN_MIN  = 1024,
	parameter int unsigned PAN_MAX  = 3072,
	parameter int unsigned TILT_MIN = 1024,
	parameter int unsigned TILT_MAX = 3072,
	parameter int unsigned CENTER_X = 160,
	parameter int unsigned CENTER_Y = 120
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cmd_t  cmd,
	output stat_t      stat,
	kpd_in_if.sink     in_ch,
	kpd_out_if.source  out_ch,
	kpd_cfg_if.sink    cfg_ch
);
	logic signed [15:0] kp_q [2];
	logic signed [15:0] kd_q [2];
	logic [31:0]        q_q  [2];
	logic [31:0]        r_q  [2];
	logic [15:0]        est_q [2];
	logic [31:0]        var_q [2];
	logic signed [16:0] lerr_q [2];
	logic [11:0]        pos_q [2];
	logic [15:0]        meas_q [2];
	logic               on_q;
	logic [3:0]         pass_q;
	logic [31:0]        pt_q;
	logic signed [16:0] err_q;
	logic signed [33:0] pterm_q, dterm_q;
	logic               ov_q;
	logic [11:0]        pan_out_q, tilt_out_q;

	logic               ax;
	logic [32:0]        ptsum;
	logic [16:0]        k;
	logic [16:0]        kg;
	logic               dbusy;
	logic signed [16:0] diff;
	logic signed [34:0] kdiff;
	logic signed [34:0] kstep;
	logic [16:0]        onemk;
	logic [48:0]        vprod;
	logic [15:0]        filt;
	logic signed [16:0] err_n;
	logic signed [17:0] derr;
	logic signed [34:0] pprod;
	logic signed [35:0] dprod;
	logic signed [35:0] npos;
	logic [11:0]        lo, hi;

	assign ax = cmd.sel_axis;
	assign ptsum = {1'b0, var_q[ax]} + {1'b0, q_q[ax]};

	kpd_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_go), .pt(pt_q),
		.den({1'b0, pt_q} + {1'b0, r_q[ax]}), .busy(dbusy), .quot(k)
	);

	// a zero denominator leaves the quotient at all ones; take it as zero
	assign kg = (pt_q == 32'd0 && r_q[ax] == 32'd0) ? 17'd0 : k;

	assign diff  = $signed({1'b0, meas_q[ax]}) - $signed({1'b0, est_q[ax]});
	assign kdiff = $signed({1'b0, kg}) * diff;
	assign kstep = (kdiff < 0) ? -((-kdiff) >>> 16) : (kdiff >>> 16);
	assign onemk = 17'd65536 - kg;
	assign vprod = {16'd0, onemk} * {17'd0, pt_q};

	// PD terms, truncated toward zero
	assign filt  = on_q ? est_q[ax] : meas_q[ax];
	assign err_n = $signed({1'b0, (ax ? CENTER_X[15:0] : CENTER_Y[15:0])}) -
		$signed({1'b0, filt});
	assign derr  = 18'(err_n) - 18'(lerr_q[ax]);
	assign pprod = 35'(err_n) * 35'(kp_q[ax]);
	assign dprod = 36'(derr) * 36'(kd_q[ax]);
	assign npos  = 36'($signed({1'b0, pos_q[ax]})) + 36'(pterm_q) + 36'(dterm_q);
	assign lo    = ax ? TILT_MIN[11:0] : PAN_MIN[11:0];
	assign hi    = ax ? TILT_MAX[11:0] : PAN_MAX[11:0];

	assign in_ch.ready  = cmd.load;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = ov_q;
	assign out_ch.pan_position  = pan_out_q;
	assign out_ch.tilt_position = tilt_out_q;
	assign stat.meas_on     = on_q;
	assign stat.passes      = pass_q;
	assign stat.div_busy    = dbusy;
	assign stat.out_busy    = ov_q;

	// configuration and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				kp_q[i] <= '0; kd_q[i] <= '0; q_q[i] <= '0; r_q[i] <= 32'd65536;
				est_q[i] <= '0; var_q[i] <= '0; lerr_q[i] <= '0; pos_q[i] <= '0;
			end
			ov_q <= 1'b0;
		end else begin
			if (cfg_ch.valid) begin
				unique case (cfg_ch.index)
					3'(REG_PAN_KP):  kp_q[0] <= cfg_ch.data[15:0];
					3'(REG_PAN_KD):  kd_q[0] <= cfg_ch.data[15:0];
					3'(REG_TILT_KP): kp_q[1] <= cfg_ch.data[15:0];
					3'(REG_TILT_KD): kd_q[1] <= cfg_ch.data[15:0];
					3'(REG_Y_Q):     q_q[0] <= cfg_ch.data;
					3'(REG_Y_R):     r_q[0] <= cfg_ch.data;
					3'(REG_X_Q):     q_q[1] <= cfg_ch.data;
					3'(REG_X_R):     r_q[1] <= cfg_ch.data;
					default: ;
				endcase
			end
			if (cmd.est) est_q[ax] <= est_q[ax] + kstep[15:0];
			if (cmd.var_upd) var_q[ax] <= vprod[47:16];
			if (cmd.pd2) begin
				lerr_q[ax] <= err_q;
				if (npos > $signed(36'(hi))) pos_q[ax] <= hi;
				else if (npos < $signed(36'(lo))) pos_q[ax] <= lo;
				else pos_q[ax] <= npos[11:0];
			end
			if (cmd.out_go) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q[0] <= in_ch.target_y;
			meas_q[1] <= in_ch.target_x;
			on_q      <= in_ch.measure_enable;
			pass_q    <= in_ch.filter_passes;
		end
		if (cmd.pred) pt_q <= ptsum[32] ? 32'hFFFF_FFFF : ptsum[31:0];
		if (cmd.pd1) begin
			err_q   <= err_n;
			pterm_q <= 34'((pprod < 0) ? -((-pprod) >>> 8) : (pprod >>> 8));
		end
		if (cmd.pd1) dterm_q <= 34'((dprod < 0) ? -((-dprod) >>> 8) : (dprod >>> 8));
		if (cmd.out_go) begin
			pan_out_q  <= pos_q[0];
			tilt_out_q <= pos_q[1];
		end
	end
endmodule
`default_nettype wire

>>> rtl/kpd_ctrl.sv
// Controller: sequences Kalman passes and PD update per axis, then the result.
`default_nettype none
module kpd_ctrl
	import kpd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  stat_t     stat,
	input  wire logic [3:0] passes_in,
	output cmd_t      cmd,
	output logic      ax_o
);
	state_t st_q, st_n;
	logic   ax_q, ax_n;
	logic [3:0] pass_q, pass_n;

	assign ax_o = ax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; ax_q <= 1'b0; pass_q <= 4'd0;
		end else begin
			st_q <= st_n; ax_q <= ax_n; pass_q <= pass_n;
		end
	end

	always_comb begin
		st_n = st_q; ax_n = ax_q; pass_n = pass_q;
		cmd = '0;
		cmd.sel_axis = ax_q;
		unique case (st_q)
			ST_IDLE: begin
				cmd.load = 1'b1;
				if (in_valid) begin
					pass_n = passes_in; ax_n = 1'b0; st_n = ST_AXIS;
				end
			end
			ST_AXIS: st_n = (stat.meas_on && pass_q != 4'd0) ? ST_PRED : ST_PD1;
			ST_PRED: begin cmd.pred = 1'b1; st_n = ST_DIV; end
			ST_DIV: begin cmd.div_go = 1'b1; st_n = ST_EST; end
			ST_EST: if (!stat.div_busy) begin cmd.est = 1'b1; st_n = ST_VAR; end
			ST_VAR: begin
				cmd.var_upd = 1'b1; pass_n = pass_q - 4'd1;
				st_n = (pass_q == 4'd1) ? ST_PD1 : ST_PRED;
			end
			ST_PD1: begin cmd.pd1 = 1'b1; st_n = ST_PD2; end
			ST_PD2: begin
				cmd.pd2 = 1'b1;
				if (ax_q) st_n = ST_OUT;
				else begin ax_n = 1'b1; pass_n = stat.passes; st_n = ST_AXIS; end
			end
			// wait for the previous result to be taken
			ST_OUT: if (!stat.out_busy) begin cmd.out_go = 1'b1; st_n = ST_IDLE; end
			default: st_n = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

>>> rtl/kalman_pd_head_tracker_core.sv
// Top level of the head tracker core.
// channel | dir | handshake   | payload
// in_ch   | in  | valid/ready | target_x, target_y, measure_enable, filter_passes
// out_ch  | out | valid/ready | pan_position, tilt_position
// cfg_ch  | in  | valid/ready | index, data (always ready)
// Per axis, each Kalman pass runs the predict, divide, estimate and variance
// steps, the estimate waiting on the divider; with filtering off only PD runs.
// At most fifteen passes per axis.
// Reset clears the gains, Q, Kalman and PD state and sets R to 65536; no clearing pass is needed.
// A held result stalls the next item only at its final step, until it is taken.
`default_nettype none
`include "kalman_pd_head_tracker_core_assert.svh"
module kalman_pd_head_tracker_core
	import kpd_pkg::*;
#(
	parameter int unsigned PAN_MIN  = 1024,
	parameter int unsigned PAN_MAX  = 3072,
	parameter int unsigned TILT_MIN = 1024,
	parameter int unsigned TILT_MAX = 3072,
	parameter int unsigned CENTER_X = 160,
	parameter int unsigned CENTER_Y = 120
) (
	input wire logic clk,
	input wire logic arst_n,
	kpd_in_if.sink    in_ch,
	kpd_out_if.source out_ch,
	kpd_cfg_if.sink   cfg_ch
);
	cmd_t  cmd, cmd_d;
	stat_t stat;
	logic  ax;

	kpd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .stat(stat),
		.passes_in(in_ch.filter_passes), .cmd(cmd), .ax_o(ax)
	);

	always_comb begin
		cmd_d = cmd;
		cmd_d.sel_axis = ax;
	end

	kpd_datapath #(
		.PAN_MIN(PAN_MIN), .PAN_MAX(PAN_MAX), .TILT_MIN(TILT_MIN),
		.TILT_MAX(TILT_MAX), .CENTER_X(CENTER_X), .CENTER_Y(CENTER_Y)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd_d), .stat(stat),
		.in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	`KPD_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.pan_position) && $stable(out_ch.tilt_position))
	`KPD_ASSERT_NEXT(a_out_after_go, cmd.out_go, out_ch.valid)
	`KPD_ASSERT_IMP(a_est_div_done, cmd.est, !stat.div_busy)
endmodule
`default_nettype wire

>>> sim/kalman_pd_head_tracker_core_test.sv
// Self-checking bench for the head tracker core: random and directed targets, checked per result.
`timescale 1ns / 100ps
`default_nettype none
module kalman_pd_head_tracker_core_test;
	import kpd_pkg::*;

	localparam int PAN_MIN = 1024, PAN_MAX = 3072, TILT_MIN = 1024, TILT_MAX = 3072;
	localparam int CENTER_X = 160, CENTER_Y = 120;

	typedef struct {
		logic [15:0] tx;
		logic [15:0] ty;
		logic        meas;
		logic [3:0]  passes;
	} target_t;

	typedef struct {
		logic [11:0] pan;
		logic [11:0] tilt;
	} servo_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kpd_in_if  in_ch ();
	kpd_out_if out_ch ();
	kpd_cfg_if cfg_ch ();

	kalman_pd_head_tracker_core DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	// predictor state
	longint      gain_kp[2], gain_kd[2];
	logic [31:0] noise_q[2], noise_r[2];
	logic [11:0] servo_pos[2];
	logic [31:0] est_st[2], var_st[2];
	longint      last_err[2];

	target_t pending_targets[$];
	servo_t  expected_servos[$];
	int      send_idle_pct = 8, recv_idle_pct = 85;
	int      mismatches = 0, targets_sent = 0, servos_checked = 0;
	bit      sender_hold = 1'b0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("timeout");
		$display("*** FAILED ***");
		$finish;
	end

	function automatic longint sext16(logic [31:0] v);
		return longint'($signed(v[15:0]));
	endfunction

	// scalar Kalman passes on one axis
	function automatic longint kalman_filter(int ax, longint meas, int passes);
		longint unsigned pt, den, k;
		longint e, diff;
		for (int i = 0; i < passes; i++) begin
			pt = longint'(var_st[ax]) + longint'(noise_q[ax]);
			if (pt > 64'hFFFF_FFFF) pt = 64'hFFFF_FFFF;
			den = pt + noise_r[ax];
			k = (den != 0) ? (pt << 16) / den : 0;
			e = longint'(est_st[ax][15:0]);
			diff = meas - e;
			e = e + (longint'(k) * diff) / 65536;
			est_st[ax] = e[31:0];
			var_st[ax] = 32'(((64'd65536 - k) * pt) >> 16);
		end
		return longint'(est_st[ax][15:0]);
	endfunction

	function automatic logic [11:0] pd_servo(int ax, longint meas, longint centre,
			longint lo, longint hi);
		longint err, p, d, np;
		err = centre - meas;
		p = (err * gain_kp[ax]) / 256;
		d = ((err - last_err[ax]) * gain_kd[ax]) / 256;
		np = longint'(servo_pos[ax]) + p + d;
		last_err[ax] = err;
		if (np > hi) np = hi;
		else if (np < lo) np = lo;
		return np[11:0];
	endfunction

	function automatic servo_t track_target(target_t t);
		servo_t s;
		longint fy, fx;
		fy = t.ty;
		fx = t.tx;
		if (t.meas) fy = kalman_filter(0, t.ty, t.passes);
		servo_pos[0] = pd_servo(0, fy, CENTER_Y, PAN_MIN, PAN_MAX);
		if (t.meas) fx = kalman_filter(1, t.tx, t.passes);
		servo_pos[1] = pd_servo(1, fx, CENTER_X, TILT_MIN, TILT_MAX);
		s.pan = servo_pos[0];
		s.tilt = servo_pos[1];
		return s;
	endfunction

	task automatic report(string what, logic [11:0] got, logic [11:0] want);
		mismatches++;
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
	endtask

	// register write, predictor updated on the transfer
	task automatic write_reg(int unsigned idx, logic [31:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx[2:0];
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_PAN_KP:  gain_kp[0] = sext16(val);
			REG_PAN_KD:  gain_kd[0] = sext16(val);
			REG_TILT_KP: gain_kp[1] = sext16(val);
			REG_TILT_KD: gain_kd[1] = sext16(val);
			REG_Y_Q:     noise_q[0] = val;
			REG_Y_R:     noise_r[0] = val;
			REG_X_Q:     noise_q[1] = val;
			REG_X_R:     noise_r[1] = val;
			default: ;
		endcase
	endtask

	// back-to-back register writes, valid dropped after the last transfer
	task automatic write_all(logic [15:0] kp0, logic [15:0] kd0, logic [15:0] kp1,
			logic [15:0] kd1, logic [31:0] q0, logic [31:0] r0, logic [31:0] q1,
			logic [31:0] r1);
		write_reg(REG_PAN_KP, {16'h0, kp0});
		write_reg(REG_PAN_KD, {16'h0, kd0});
		write_reg(REG_TILT_KP, {16'h0, kp1});
		write_reg(REG_TILT_KD, {16'h0, kd1});
		write_reg(REG_Y_Q, q0);
		write_reg(REG_Y_R, r0);
		write_reg(REG_X_Q, q1);
		write_reg(REG_X_R, r1);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic queue_target(logic [15:0] tx, logic [15:0] ty, logic meas,
			logic [3:0] passes);
		target_t t;
		t.tx = tx;
		t.ty = ty;
		t.meas = meas;
		t.passes = passes;
		pending_targets.push_back(t);
	endtask

	// wait for all results, then a settling gap before touching registers
	task automatic drain();
		while (pending_targets.size() != 0 || in_ch.valid || expected_servos.size() != 0)
			@(negedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			// mostly small pass counts; some drawn from the full range
			queue_target($urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 400)),
				$urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 300)),
				$urandom_range(0, 4) != 0,
				$urandom_range(0, 9) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3)));
		end
	endtask

	// stimulus
	initial begin
		gain_kp = '{0, 0};
		gain_kd = '{0, 0};
		noise_q = '{0, 0};
		noise_r = '{65536, 65536};
		servo_pos = '{0, 0};
		est_st = '{0, 0};
		var_st = '{0, 0};
		last_err = '{0, 0};
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, then edge values and special cases
		queue_target(16'd0, 16'd0, 1'b0, 4'd0);
		queue_target(16'hFFFF, 16'hFFFF, 1'b1, 4'd15);
		queue_target(16'd160, 16'd120, 1'b1, 4'd0);
		drain();
		write_all(16'h0100, 16'h0040, 16'h0100, 16'h0040, 32'h0000_1000, 32'h0001_0000,
			32'h0, 32'h0);
		queue_target(16'd0, 16'd0, 1'b1, 4'd1);       // zero denominator on x
		queue_target(16'hFFFF, 16'hFFFF, 1'b1, 4'd15);
		queue_target(16'd300, 16'd50, 1'b0, 4'd7);
		queue_target(16'd160, 16'd120, 1'b1, 4'd2);
		drain();
		write_all(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFF0, 32'h0);                      // variance saturation
		queue_target(16'hFFFF, 16'd0, 1'b1, 4'd15);
		queue_target(16'd0, 16'hFFFF, 1'b1, 4'd15);
		queue_target(16'h5555, 16'hAAAA, 1'b0, 4'd5);
		queue_target(16'hAAAA, 16'h5555, 1'b1, 4'd10);
		queue_target(16'd1, 16'd1, 1'b1, 4'd3);
		drain();

		// random phases with changing settings
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 85;
				recv_idle_pct = 8;
			end
			if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_all(16'($urandom_range(0, 1023)) - 16'd512,
				16'($urandom_range(0, 1023)) - 16'd512,
				16'($urandom_range(0, 1023)) - 16'd512, 16'($urandom),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h4_0000),
				$urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h4_0000),
				$urandom, $urandom_range(0, 32'h4_0000));
			queue_random(60);
			// hold the sender until everything outstanding has come back
			while (pending_targets.size() > 20) @(negedge clk);
			sender_hold = 1'b1;
			do @(negedge clk); while (in_ch.valid || expected_servos.size() != 0);
			sender_hold = 1'b0;
			queue_random(55);
			drain();
		end

		$display("sent %0d targets, checked %0d servo results over six setting phases",
			targets_sent, servos_checked);
		$display("covered raw and filtered paths, 0..15 passes, gain and noise extremes");
		if (mismatches == 0 && expected_servos.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.target_x <= '0;
			in_ch.target_y <= '0;
			in_ch.measure_enable <= 1'b0;
			in_ch.filter_passes <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid) begin
				target_t t;
				t.tx = in_ch.target_x;
				t.ty = in_ch.target_y;
				t.meas = in_ch.measure_enable;
				t.passes = in_ch.filter_passes;
				expected_servos.push_back(track_target(t));
				targets_sent++;
			end
			if (pending_targets.size() != 0 && !sender_hold &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				target_t n;
				n = pending_targets.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.target_x <= n.tx;
				in_ch.target_y <= n.ty;
				in_ch.measure_enable <= n.meas;
				in_ch.filter_passes <= n.passes;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_servos.size() == 0) begin
					report("unexpected result", out_ch.pan_position, 12'd0);
				end else begin
					servo_t s;
					s = expected_servos.pop_front();
					servos_checked++;
					if (out_ch.pan_position !== s.pan)
						report("pan_position", out_ch.pan_position, s.pan);
					if (out_ch.tilt_position !== s.tilt)
						report("tilt_position", out_ch.tilt_position, s.tilt);
				end
			end
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end
endmodule
`default_nettype wire

>>> kalman_pd_head_tracker_core.f
+incdir+rtl
rtl/kpd_pkg.sv
rtl/kpd_if.sv
rtl/kpd_divider.sv
rtl/kpd_datapath.sv
rtl/kpd_ctrl.sv
rtl/kalman_pd_head_tracker_core.sv
sim/kalman_pd_head_tracker_core_test.sv
